// ----- rtl/polygon_normal_newell_defines.svh -----
// Assertion macros shared by the polygon normal RTL.
// No dependencies; included by the modules that carry checks.
`ifndef POLYGON_NORMAL_NEWELL_DEFINES_SVH
`define POLYGON_NORMAL_NEWELL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PNN_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PNN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pnn_pkg.sv -----
// Shared constants, types and back-end state encoding for the polygon normal block.
// No dependencies; imported by every module of the block.
package pnn_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int SUM_W           = 45;              // Newell accumulator width
    localparam int Q_DEPTH         = 4;               // finished sums awaiting normalization
    localparam int QPTR_W          = $clog2(Q_DEPTH);
    localparam int QCNT_W          = $clog2(Q_DEPTH + 1);
    localparam int NORM_W          = 30;              // magnitudes scaled below 2^NORM_W
    localparam int SQ_W            = 2 * NORM_W + 2;  // sum of three squares
    localparam int ROOT_W          = NORM_W + 1;
    localparam int DVS_W           = ROOT_W + 1;      // divisor is twice the length
    localparam int NUM_W           = NORM_W + 16;     // 32768 * mag + len
    localparam int OUT_W           = 16;              // Q1.14 component
    localparam int QDIG_W          = $clog2(OUT_W);
    localparam int OUT_DW          = 3 * OUT_W;

    typedef struct packed {
        logic [SUM_W-1:0] z;
        logic [SUM_W-1:0] y;
        logic [SUM_W-1:0] x;
    } sum_vec_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SHIFT,
        B_SQSUM,
        B_SQRT,
        B_DIVLD,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

// ----- rtl/polygon_normal_newell.sv -----
// Polygon normal by Newell's method: top level with stream ports.
// Depends on pnn_pkg, pnn_front, pnn_queue and pnn_back.
//
// Usage: vertices arrive on the s_ channel, one item per vertex, s_tlast set on
// the final vertex of a polygon. One result per polygon leaves on the m_ channel:
// the unit normal in Q1.14 (16384 = 1.0) and a degenerate flag in m_tuser that is
// set, with all components zero, when the Newell sum is zero.
// Throughput: one vertex per cycle while the queue has room; s_tready drops after
// the last vertex of a polygon while the closing edge, which shares the single
// set of x, y and z edge multipliers, is issued; it then passes the edge-operand
// and product registers into the sum and the queue. Before m_tvalid rises the
// normalizer runs a one-bit-per-cycle prescale, one shared 30x30 multiplier over
// three squares, a bit-serial square root and three bit-serial divides; a zero sum skips all.
// Up to four finished sums wait in the queue between accumulator and normalizer,
// so short polygons are absorbed; once it is full s_tready drops.
// A stalled m_tready holds the result and parks the normalizer; vertex intake
// continues until the queue fills. aresetn (synchronous) empties the queue and
// clears all polygon state; no clearing pass is needed.
module polygon_normal_newell #(
    parameter int COORD_WIDTH = pnn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,  // vertex_x, vertex_y, vertex_z
    input  logic                                 s_tlast,  // last_vertex
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pnn_pkg::OUT_DW-1:0]           m_tdata,  // normal_x, normal_y, normal_z
    output logic                                 m_tuser   // degenerate
);
    import pnn_pkg::*;

    logic signed [COORD_WIDTH-1:0] vx, vy, vz;
    q_status_t                     q_status;
    sum_vec_t                      push_data, head;
    logic                          push, pop;
    logic [OUT_W-1:0]              nx, ny, nz;

    assign vx = s_tdata[COORD_WIDTH-1:0];
    assign vy = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign vz = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

    pnn_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .vertex_x    (vx),
        .vertex_y    (vy),
        .vertex_z    (vz),
        .last_vertex (s_tlast),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    pnn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    pnn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .normal_x   (nx),
        .normal_y   (ny),
        .normal_z   (nz),
        .degenerate (m_tuser)
    );

    assign m_tdata = {nz, ny, nx};

endmodule

// ----- rtl/pnn_front.sv -----
// Vertex intake and Newell accumulation: edge operands, products, 45-bit sums.
// Depends on pnn_pkg; pushes finished sums into pnn_queue.
`include "polygon_normal_newell_defines.svh"

module pnn_front #(
    parameter int COORD_WIDTH = pnn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_z,
    input  logic                          last_vertex,
    input  pnn_pkg::q_status_t            q_status,
    output logic                          push,
    output pnn_pkg::sum_vec_t             push_data
);
    import pnn_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_WIDTH-1:0] first_reg [3];
    logic signed [COORD_WIDTH-1:0] prev_reg  [3];
    logic signed [COORD_WIDTH-1:0] vin       [3];
    logic signed [COORD_WIDTH-1:0] opb       [3];
    logic                          have_reg, pend_reg;
    logic                          e_valid_reg, e_close_reg;
    logic signed [DW-1:0]          e_d_reg [3], e_s_reg [3];
    logic signed [DW-1:0]          e_d_next [3], e_s_next [3];
    logic                          p_valid_reg, p_close_reg;
    logic signed [PW-1:0]          p_prod_reg [3];
    logic signed [SUM_W-1:0]       sum_reg  [3];
    logic signed [SUM_W-1:0]       sum_next [3];
    logic [QCNT_W:0]               credit;
    logic                          accept, issue;

    assign vin[0] = vertex_x;
    assign vin[1] = vertex_y;
    assign vin[2] = vertex_z;

    // slots held by closes still in flight count against the queue
    assign credit  = (QCNT_W+1)'(q_status.count) + (QCNT_W+1)'(e_close_reg)
                   + (QCNT_W+1)'(p_close_reg);
    assign s_ready = !pend_reg && (credit < (QCNT_W+1)'(Q_DEPTH));
    assign accept  = s_valid && s_ready;
    // closing edge goes out the cycle after the last vertex
    assign issue   = pend_reg || (accept && have_reg);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            opb[i] = pend_reg ? first_reg[i] : vin[i];
        end
        e_d_next[0] = DW'(prev_reg[1]) - DW'(opb[1]);
        e_s_next[0] = DW'(prev_reg[2]) + DW'(opb[2]);
        e_d_next[1] = DW'(prev_reg[2]) - DW'(opb[2]);
        e_s_next[1] = DW'(prev_reg[0]) + DW'(opb[0]);
        e_d_next[2] = DW'(prev_reg[0]) - DW'(opb[0]);
        e_s_next[2] = DW'(prev_reg[1]) + DW'(opb[1]);
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = sum_reg[i] + SUM_W'(p_prod_reg[i]);
        end
    end

    assign push        = p_valid_reg && p_close_reg;
    assign push_data.x = sum_next[0];
    assign push_data.y = sum_next[1];
    assign push_data.z = sum_next[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            e_valid_reg <= 1'b0;
            e_close_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            p_close_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            e_valid_reg <= issue;
            e_close_reg <= pend_reg;
            p_valid_reg <= e_valid_reg;
            p_close_reg <= e_valid_reg && e_close_reg;
            if (pend_reg) begin
                pend_reg <= 1'b0;
                have_reg <= 1'b0;
            end else if (accept) begin
                have_reg <= 1'b1;
                pend_reg <= last_vertex;
            end
            if (p_valid_reg) begin
                for (int i = 0; i < 3; i++) begin
                    sum_reg[i] <= p_close_reg ? '0 : sum_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (issue) begin
                e_d_reg[i] <= e_d_next[i];
                e_s_reg[i] <= e_s_next[i];
            end
            if (accept) begin
                prev_reg[i] <= vin[i];
            end
            if (accept && !have_reg) begin
                first_reg[i] <= vin[i];
            end
            if (e_valid_reg) begin
                p_prod_reg[i] <= e_d_reg[i] * e_s_reg[i];
            end
        end
    end

    `PNN_ASSERT_NEXT(a_last_sets_pend, aclk, aresetn, accept && last_vertex, pend_reg, "last vertex did not schedule closing edge")
    `PNN_ASSERT_NEXT(a_close_issued, aclk, aresetn, pend_reg, e_valid_reg && e_close_reg && !pend_reg && !have_reg, "closing edge not issued")
    `PNN_ASSERT_NOW(a_push_room, aclk, aresetn, push, q_status.count < QCNT_W'(Q_DEPTH), "sum pushed without reserved queue slot")

endmodule

// ----- rtl/pnn_queue.sv -----
// Short FIFO of finished Newell sums between the accumulator and the normalizer.
// Depends on pnn_pkg.
`include "polygon_normal_newell_defines.svh"

module pnn_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pnn_pkg::sum_vec_t  push_data,
    input  logic               pop,
    output pnn_pkg::sum_vec_t  head,
    output pnn_pkg::q_status_t status
);
    import pnn_pkg::*;

    sum_vec_t          slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head          = slot_reg[rd_ptr_reg];
    assign status.count  = count_reg;
    assign status.empty  = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PNN_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, count_reg < QCNT_W'(Q_DEPTH), "queue overflow")
    `PNN_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop, count_reg != '0, "queue underflow")

endmodule

// ----- rtl/pnn_back.sv -----
// Normalizer: scales the Newell sum, sums squares, square root, then three divides.
// Depends on pnn_pkg; pops sums from pnn_queue and drives the result register.
`include "polygon_normal_newell_defines.svh"

module pnn_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pnn_pkg::q_status_t           q_status,
    input  pnn_pkg::sum_vec_t            head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pnn_pkg::OUT_W-1:0]    normal_x,
    output logic [pnn_pkg::OUT_W-1:0]    normal_y,
    output logic [pnn_pkg::OUT_W-1:0]    normal_z,
    output logic                         degenerate
);
    import pnn_pkg::*;

    back_state_t       state_reg, state_next;
    logic              m_valid_reg, load_out;

    logic              neg_reg [3];
    logic [SUM_W-1:0]  mag_reg [3];
    logic [SUM_W-1:0]  head_s  [3];
    logic              deg_reg;
    logic [OUT_W-1:0]  res_reg [3];
    logic [OUT_W-1:0]  out_reg [3];
    logic              out_deg_reg;
    logic              all_zero, too_big;

    logic [1:0]        sq_cnt_reg;
    logic [NORM_W-1:0] sq_sel;
    logic [2*NORM_W-1:0] sq_prod_reg;
    logic [SQ_W-1:0]   acc_reg;
    logic [SQ_W-1:0]   root_reg, bit_reg;
    logic [SQ_W:0]     trial;

    logic [1:0]        ci_reg;
    logic [QDIG_W-1:0] dcnt_reg;
    logic [ROOT_W-1:0] len;
    logic [NORM_W-1:0] mag_c;
    logic              neg_c;
    logic [NUM_W-1:0]  num;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_reg, rem_try, rem_next;
    logic [OUT_W-1:0]  numlo_reg, q_reg, q_next;

    assign head_s[0] = head.x;
    assign head_s[1] = head.y;
    assign head_s[2] = head.z;
    assign all_zero  = (head.x == '0) && (head.y == '0) && (head.z == '0);
    assign too_big   = (|mag_reg[0][SUM_W-1:NORM_W]) || (|mag_reg[1][SUM_W-1:NORM_W])
                    || (|mag_reg[2][SUM_W-1:NORM_W]);

    always_comb begin
        case (sq_cnt_reg)
            2'd0:    sq_sel = mag_reg[0][NORM_W-1:0];
            2'd1:    sq_sel = mag_reg[1][NORM_W-1:0];
            2'd2:    sq_sel = mag_reg[2][NORM_W-1:0];
            default: sq_sel = '0;
        endcase
        case (ci_reg)
            2'd0:    begin mag_c = mag_reg[0][NORM_W-1:0]; neg_c = neg_reg[0]; end
            2'd1:    begin mag_c = mag_reg[1][NORM_W-1:0]; neg_c = neg_reg[1]; end
            2'd2:    begin mag_c = mag_reg[2][NORM_W-1:0]; neg_c = neg_reg[2]; end
            default: begin mag_c = '0; neg_c = 1'b0; end
        endcase
    end

    assign trial = (SQ_W+1)'(root_reg) + (SQ_W+1)'(bit_reg);
    assign len   = (root_reg[ROOT_W-1:0] == '0) ? ROOT_W'(1) : root_reg[ROOT_W-1:0];
    // 2 * 16384 * mag + len, later divided by 2 * len for round-half-up
    assign num   = (NUM_W'(mag_c) << (OUT_W - 1)) + NUM_W'(len);

    assign rem_try = {rem_reg[DVS_W-1:0], numlo_reg[OUT_W-1]};
    always_comb begin
        if (rem_try >= (DVS_W+1)'(dvs_reg)) begin
            rem_next = rem_try - (DVS_W+1)'(dvs_reg);
            q_next   = {q_reg[OUT_W-2:0], 1'b1};
        end else begin
            rem_next = rem_try;
            q_next   = {q_reg[OUT_W-2:0], 1'b0};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!q_status.empty) state_next = all_zero ? B_OUT : B_SHIFT;
            B_SHIFT: if (!too_big) state_next = B_SQSUM;
            B_SQSUM: if (sq_cnt_reg == 2'd3) state_next = B_SQRT;
            B_SQRT:  if (bit_reg[0]) state_next = B_DIVLD;
            B_DIVLD: state_next = B_DIV;
            B_DIV:   if (dcnt_reg == '0) state_next = (ci_reg == 2'd2) ? B_OUT : B_DIVLD;
            B_OUT:   if (!m_valid_reg || m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:  pop = !q_status.empty;
            B_OUT:   load_out = !m_valid_reg || m_ready;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= head_s[i][SUM_W-1];
                    mag_reg[i] <= head_s[i][SUM_W-1] ? (SUM_W'(0) - head_s[i]) : head_s[i];
                    res_reg[i] <= '0;
                end
                deg_reg    <= all_zero;
                sq_cnt_reg <= '0;
                acc_reg    <= '0;
            end
            B_SHIFT: begin
                if (too_big) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
            end
            B_SQSUM: begin
                if (sq_cnt_reg != 2'd3) begin
                    sq_prod_reg <= sq_sel * sq_sel;
                end
                if (sq_cnt_reg != 2'd0) begin
                    acc_reg <= acc_reg + SQ_W'(sq_prod_reg);
                end
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
                root_reg   <= '0;
                bit_reg    <= SQ_W'(1) << (SQ_W - 2);
            end
            B_SQRT: begin
                if ((SQ_W+1)'(acc_reg) >= trial) begin
                    acc_reg  <= acc_reg - trial[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                ci_reg  <= '0;
            end
            B_DIVLD: begin
                dvs_reg   <= {len, 1'b0};
                rem_reg   <= (DVS_W+1)'(num[NUM_W-1:OUT_W]);
                numlo_reg <= num[OUT_W-1:0];
                q_reg     <= '0;
                dcnt_reg  <= QDIG_W'(OUT_W - 1);
            end
            B_DIV: begin
                rem_reg   <= rem_next;
                q_reg     <= q_next;
                numlo_reg <= numlo_reg << 1;
                dcnt_reg  <= dcnt_reg - 1'b1;
                if (dcnt_reg == '0) begin
                    case (ci_reg)
                        2'd0:    res_reg[0] <= neg_c ? (OUT_W'(0) - q_next) : q_next;
                        2'd1:    res_reg[1] <= neg_c ? (OUT_W'(0) - q_next) : q_next;
                        default: res_reg[2] <= neg_c ? (OUT_W'(0) - q_next) : q_next;
                    endcase
                    ci_reg <= ci_reg + 2'd1;
                end
            end
            default: begin
                if (load_out) begin
                    for (int i = 0; i < 3; i++) begin
                        out_reg[i] <= res_reg[i];
                    end
                    out_deg_reg <= deg_reg;
                end
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign normal_x   = out_reg[0];
    assign normal_y   = out_reg[1];
    assign normal_z   = out_reg[2];
    assign degenerate = out_deg_reg;

    `PNN_ASSERT_NEXT(a_out_held, aclk, aresetn, (state_reg == B_OUT) && m_valid_reg && !m_ready, state_reg == B_OUT, "result register overwritten while stalled")
    `PNN_ASSERT_NOW(a_deg_zero, aclk, aresetn, m_valid_reg && out_deg_reg, (out_reg[0] == '0) && (out_reg[1] == '0) && (out_reg[2] == '0), "degenerate result with nonzero components")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for polygon_normal_newell: polygon vertices in, unit normals out.
// Depends on pnn_pkg and the polygon_normal_newell RTL; the expected normals come from an
// in-file Newell accumulator and normalizer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AT     = 100;    // start the long output hold after this many vertices
    localparam int HOLD_CYCLES = 2000;
    localparam int STALL_LIMIT = 20000;  // cycles with no item moving on either side
    localparam int TAIL_CYCLES = 150;
    localparam int RANDOM_ITEMS = 560;
    localparam int LONG_VERTS  = 256;    // one long polygon
    localparam int MAX_PRINTS  = 20;

    // polygon shapes for the random part
    localparam int P_FULL    = 0;
    localparam int P_SMALL   = 1;
    localparam int P_EXTREME = 2;
    localparam int P_PLANAR  = 3;
    localparam int P_LINE    = 4;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
        bit                 drain;  // hold this item until every normal has come back
    } vertex_t;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
    } normal_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [47:0]               s_tdata = '0;  // vertex_x, vertex_y, vertex_z
    logic                      s_tlast = 1'b0;  // last_vertex
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [pnn_pkg::OUT_DW-1:0] m_tdata;  // normal_x, normal_y, normal_z
    logic                      m_tuser;  // degenerate

    polygon_normal_newell dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    vertex_t pending_vertices[$];
    normal_t expected_normals[$];

    // predictor state
    logic signed [15:0] first_x, first_y, first_z;
    logic signed [15:0] prev_x, prev_y, prev_z;
    logic [44:0]        acc_x, acc_y, acc_z;
    bit                 started;

    int fail_count = 0;
    int vertices_in = 0;
    int results_seen = 0;
    int degenerate_seen = 0;
    int polygons_queued = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [44:0] newell_term(input logic signed [15:0] p, q, r, s);
        longint diff, total, prod;
        diff = longint'(p) - longint'(q);
        total = longint'(r) + longint'(s);
        prod = diff * total;
        return prod[44:0];
    endfunction

    task automatic add_edge(input logic signed [15:0] ax, ay, az, bx, by, bz);
        acc_x += newell_term(ay, by, az, bz);
        acc_y += newell_term(az, bz, ax, bx);
        acc_z += newell_term(ax, bx, ay, by);
    endtask

    function automatic logic [63:0] magnitude(input logic [44:0] s);
        if (s[44])
            return (64'd1 << 45) - {19'd0, s};
        return {19'd0, s};
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, cand;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    // round half up of 16384 * mag / len, then apply the sign
    function automatic logic signed [15:0] to_q14(input logic [63:0] mag, input logic neg,
                                                  input logic [63:0] len);
        logic [63:0] q;
        q = (64'd32768 * mag + len) / (64'd2 * len);
        if (neg)
            q = -q;
        return q[15:0];
    endfunction

    task automatic fold_vertex(input vertex_t v, output bit emits, output normal_t n);
        logic [63:0] a, b, c, m, len;
        int k;
        emits = 0;
        n = '{default: '0};
        if (!started) begin
            first_x = v.x;
            first_y = v.y;
            first_z = v.z;
            started = 1;
        end else begin
            add_edge(prev_x, prev_y, prev_z, v.x, v.y, v.z);
        end
        prev_x = v.x;
        prev_y = v.y;
        prev_z = v.z;
        if (!v.last)
            return;
        add_edge(v.x, v.y, v.z, first_x, first_y, first_z);
        emits = 1;
        if (acc_x == '0 && acc_y == '0 && acc_z == '0) begin
            n.degen = 1'b1;
        end else begin
            a = magnitude(acc_x);
            b = magnitude(acc_y);
            c = magnitude(acc_z);
            m = a;
            if (b > m) m = b;
            if (c > m) m = c;
            k = 0;
            while ((m >> k) >= (64'd1 << 30))
                k++;
            a = a >> k;
            b = b >> k;
            c = c >> k;
            len = int_sqrt(a * a + b * b + c * c);
            if (len == 0)
                len = 1;
            n.nx = to_q14(a, acc_x[44], len);
            n.ny = to_q14(b, acc_y[44], len);
            n.nz = to_q14(c, acc_z[44], len);
        end
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        first_x = '0; first_y = '0; first_z = '0;
        prev_x = '0; prev_y = '0; prev_z = '0;
        started = 0;
    endtask

    task automatic push_vertex(input logic signed [15:0] x, y, z, input bit last,
                               input bit drain);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        v.drain = drain;
        pending_vertices.push_back(v);
        if (last)
            polygons_queued++;
    endtask

    function automatic logic signed [15:0] pick_coord(input int style);
        logic [15:0] v;
        case (style)
            P_SMALL: begin
                v = 16'($urandom_range(0, 255));
                return v - 16'd128;
            end
            P_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random_polygon(input int count, input bit drain);
        int style, t;
        logic signed [15:0] x, y, z, bx, by, bz, dx, dy, dz, plane_z;
        style = $urandom_range(P_FULL, P_LINE);
        plane_z = 16'($urandom);
        bx = 16'($urandom_range(0, 2000)) - 16'sd1000;
        by = 16'($urandom_range(0, 2000)) - 16'sd1000;
        bz = 16'($urandom_range(0, 2000)) - 16'sd1000;
        dx = 16'($urandom_range(0, 100)) - 16'sd50;
        dy = 16'($urandom_range(0, 100)) - 16'sd50;
        dz = 16'($urandom_range(0, 100)) - 16'sd50;
        x = '0; y = '0; z = '0;
        for (int i = 0; i < count; i++) begin
            // now and then repeat the previous vertex
            if (i == 0 || $urandom_range(0, 7) != 0) begin
                case (style)
                    P_LINE: begin
                        t = $urandom_range(0, 20);
                        x = bx + 16'(t) * dx;
                        y = by + 16'(t) * dy;
                        z = bz + 16'(t) * dz;
                    end
                    P_PLANAR: begin
                        x = pick_coord(P_FULL);
                        y = pick_coord(P_FULL);
                        z = plane_z;
                    end
                    default: begin
                        x = pick_coord(style);
                        y = pick_coord(style);
                        z = pick_coord(style);
                    end
                endcase
            end
            push_vertex(x, y, z, i == count - 1, drain && i == 0);
        end
    endtask

    // big square traced over and over in one long polygon
    task automatic queue_long_polygon();
        logic signed [15:0] x, y, z;
        for (int i = 0; i < LONG_VERTS; i++) begin
            x = (i % 4 == 0 || i % 4 == 3) ? 16'sh7fff : 16'sh8000;
            y = (i % 4 < 2) ? 16'sh7fff : 16'sh8000;
            z = 16'($urandom_range(0, 2000)) - 16'sd1000;
            push_vertex(x, y, z, i == LONG_VERTS - 1, i == 0);
        end
    endtask

    // sender: bursts and gaps, fed from pending_vertices
    vertex_t cur_vertex;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        bit emits;
        normal_t n;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                fold_vertex(cur_vertex, emits, n);
                if (emits)
                    expected_normals.push_back(n);
                vertices_in <= vertices_in + 1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 5) == 0) begin
                        gap_left = 0;
                        burst_left = $urandom_range(60, 150);
                    end else begin
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 40);
                    end
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_vertices.size() == 0 ||
                             (pending_vertices[0].drain && expected_normals.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    cur_vertex = pending_vertices.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_vertex.z, cur_vertex.y, cur_vertex.x};
                    s_tlast <= cur_vertex.last;
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int hold_left = 0;
    bit hold_done = 0;
    int stall_left = 0;
    int phase_left = 0;
    bit calm = 0;

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("normal %0d %s: got %0d, expected %0d",
                                      results_seen, name, $signed(got), $signed(want)));
    endtask

    always @(posedge aclk) begin
        normal_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_normals.size() == 0) begin
                    report_mismatch($sformatf("normal %0d arrived with no polygon pending",
                                              results_seen));
                end else begin
                    want = expected_normals.pop_front();
                    check_field("normal_x", m_tdata[15:0], want.nx);
                    check_field("normal_y", m_tdata[31:16], want.ny);
                    check_field("normal_z", m_tdata[47:32], want.nz);
                    check_field("degenerate", {15'd0, m_tuser}, {15'd0, want.degen});
                end
                if (m_tuser)
                    degenerate_seen++;
                results_seen++;
            end
            if (!hold_done && vertices_in >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (phase_left == 0) begin
                calm = !calm;
                phase_left = $urandom_range(100, 400);
            end else begin
                phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 20);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int random_items;
        int count;
        bit long_done;
        acc_x = '0; acc_y = '0; acc_z = '0;
        first_x = '0; first_y = '0; first_z = '0;
        prev_x = '0; prev_y = '0; prev_z = '0;
        started = 0;

        // single vertex: closing edge is zero
        push_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1, 0);
        // two vertices: edges cancel
        push_vertex(16'sh8000, 16'sh8000, 16'sh8000, 0, 0);
        push_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 0);
        // extreme triangle
        push_vertex(16'sh7fff, 16'sh8000, 16'sh0000, 0, 0);
        push_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 0, 0);
        push_vertex(16'sh0000, 16'sh0000, 16'sh7fff, 1, 0);
        // xy triangle, both windings
        push_vertex(16'sd0, 16'sd0, 16'sd0, 0, 0);
        push_vertex(16'sd16384, 16'sd0, 16'sd0, 0, 0);
        push_vertex(16'sd0, 16'sd16384, 16'sd0, 1, 0);
        push_vertex(16'sd0, 16'sd16384, 16'sd0, 0, 0);
        push_vertex(16'sd16384, 16'sd0, 16'sd0, 0, 0);
        push_vertex(16'sd0, 16'sd0, 16'sd0, 1, 0);
        // collinear points give a zero sum
        push_vertex(16'sd1, 16'sd2, 16'sd3, 0, 0);
        push_vertex(16'sd2, 16'sd4, 16'sd6, 0, 0);
        push_vertex(16'sd3, 16'sd6, 16'sd9, 1, 0);
        // full-range square in the yz plane
        push_vertex(16'sd0, 16'sh8000, 16'sh8000, 0, 0);
        push_vertex(16'sd0, 16'sh7fff, 16'sh8000, 0, 0);
        push_vertex(16'sd0, 16'sh7fff, 16'sh7fff, 0, 0);
        push_vertex(16'sd0, 16'sh8000, 16'sh7fff, 1, 0);
        // skewed quad on the corners of the range
        push_vertex(16'sh8000, 16'sh8000, 16'sh8000, 0, 0);
        push_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0);
        push_vertex(16'sh7fff, 16'sh7fff, 16'sh8000, 0, 0);
        push_vertex(16'sh8000, 16'sh7fff, 16'sh7fff, 1, 0);
        // tiny triangle
        push_vertex(-16'sd1, -16'sd1, -16'sd1, 0, 0);
        push_vertex(16'sd0, -16'sd1, 16'sd0, 0, 0);
        push_vertex(-16'sd1, 16'sd0, 16'sd0, 1, 0);

        random_items = 0;
        long_done = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (!long_done && random_items >= RANDOM_ITEMS / 2) begin
                queue_long_polygon();
                long_done = 1;
            end
            case ($urandom_range(0, 9))
                0: count = $urandom_range(1, 2);
                1, 2: count = $urandom_range(9, 24);
                default: count = $urandom_range(3, 8);
            endcase
            queue_random_polygon(count, random_items == 0 || $urandom_range(0, 39) == 0);
            random_items += count;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_vertices.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_normals.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d vertices in %0d polygons (one of %0d vertices), incl. a %0d-cycle hold.",
                 vertices_in, polygons_queued, LONG_VERTS, HOLD_CYCLES);
        $display("Checked %0d normals, %0d of them degenerate; %0d mismatches.",
                 results_seen, degenerate_seen, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
